/* design/i2crm_pkg.sv */
// shared types and constants for the i2c register master
`timescale 1ns / 1ps

package i2crm_pkg;

  // one bus tick offered to the master
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] reg_addr;
    logic [7:0] byte_count;
    logic [7:0] write_data;
    logic       sda_in;
  } in_t;

  // bus levels and status produced for one tick
  typedef struct packed {
    logic       scl_out;
    logic       sda_release;
    logic [7:0] read_byte_out;
    logic       read_valid;
    logic       data_request;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
  } out_t;

  // configuration register indexes
  localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_PHASE_TICKS    = 2'd1;

  localparam logic [6:0] DEVICE_ADDRESS_RST = 7'd0;
  localparam logic [7:0] PHASE_TICKS_RST    = 8'd5;

  // tick ops
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_DATA  = 2'd3;

  // byte kinds, carried in the shift and ack state codes
  localparam logic [1:0] KIND_ADDR_W = 2'd0;
  localparam logic [1:0] KIND_REG    = 2'd1;
  localparam logic [1:0] KIND_ADDR_R = 2'd2;
  localparam logic [1:0] KIND_DATA   = 2'd3;

  // transaction status
  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_ADDR_NAK = 2'd1;
  localparam logic [1:0] STS_REG_NAK  = 2'd2;
  localparam logic [1:0] STS_DATA_NAK = 2'd3;

endpackage

/* design/i2crm_core.sv */
// bus sequencer: state registers and the per-tick next-state and output logic
`timescale 1ns / 1ps

module i2crm_core import i2crm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  in_t        item_i,
  input  logic [6:0] device_address_i,
  input  logic [7:0] phase_ticks_i,
  output out_t       result_o
);

  localparam logic [4:0] ST_IDLE      = 5'd0;
  localparam logic [4:0] ST_START_A   = 5'd1;
  localparam logic [4:0] ST_START_B   = 5'd2;
  localparam logic [4:0] ST_RS_A      = 5'd3;
  localparam logic [4:0] ST_RS_B      = 5'd4;
  localparam logic [4:0] ST_RS_C      = 5'd5;
  localparam logic [4:0] ST_WAIT      = 5'd6;
  localparam logic [4:0] ST_RD_LOW    = 5'd7;
  localparam logic [4:0] ST_RD_HIGH   = 5'd8;
  localparam logic [4:0] ST_MACK_LOW  = 5'd9;
  localparam logic [4:0] ST_MACK_HIGH = 5'd10;
  localparam logic [4:0] ST_STOP_A    = 5'd11;
  localparam logic [4:0] ST_STOP_B    = 5'd12;
  localparam logic [4:0] ST_STOP_C    = 5'd13;
  localparam logic [4:0] ST_TX_ADDR_W = 5'd16;
  localparam logic [4:0] ST_TX_REG    = 5'd18;
  localparam logic [4:0] ST_TX_ADDR_R = 5'd20;
  localparam logic [4:0] ST_TX_DATA   = 5'd22;

  logic [4:0] state_q, state_d, state_pre;
  logic [7:0] phase_q, phase_d, phase_inc;
  logic [3:0] bit_q, bit_d;
  logic [7:0] shift_q, shift_d;
  logic [7:0] left_q, left_d;
  logic [7:0] regb_q, regb_d;
  logic       is_read_q, is_read_d;
  logic [1:0] status_q, status_d;
  logic [7:0] ticks;
  logic [1:0] kind;

  assign ticks = (phase_ticks_i == 8'd0) ? 8'd1 : phase_ticks_i;

  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    bit_d     = bit_q;
    shift_d   = shift_q;
    left_d    = left_q;
    regb_d    = regb_q;
    is_read_d = is_read_q;
    status_d  = status_q;
    result_o  = '0;
    result_o.scl_out     = 1'b1;
    result_o.sda_release = 1'b1;

    // start of a transaction or arrival of the next write byte
    if (state_q == ST_IDLE && (item_i.op == OP_WRITE || item_i.op == OP_READ)) begin
      regb_d    = item_i.reg_addr;
      left_d    = item_i.byte_count;
      is_read_d = (item_i.op == OP_READ);
      status_d  = STS_OK;
      bit_d     = 4'd0;
      phase_d   = 8'd0;
      state_d   = ST_START_A;
    end else if (state_q == ST_WAIT && item_i.op == OP_DATA) begin
      shift_d = item_i.write_data;
      bit_d   = 4'd0;
      phase_d = 8'd0;
      state_d = ST_TX_DATA;
    end
    state_pre = state_d;
    kind      = state_pre[2:1];

    // bus levels for this tick
    if (state_pre[4] && !state_pre[3]) begin
      result_o.scl_out     = state_pre[0];
      result_o.sda_release = shift_d[7];
    end else if (state_pre[4]) begin
      result_o.scl_out     = state_pre[0];
      result_o.sda_release = 1'b1;
    end else begin
      case (state_pre)
        ST_START_B:   begin result_o.scl_out = 1'b1; result_o.sda_release = 1'b0; end
        ST_RS_A:      begin result_o.scl_out = 1'b0; result_o.sda_release = 1'b1; end
        ST_RS_C:      begin result_o.scl_out = 1'b1; result_o.sda_release = 1'b0; end
        ST_WAIT:      begin result_o.scl_out = 1'b0; result_o.sda_release = 1'b1; end
        ST_RD_LOW:    begin result_o.scl_out = 1'b0; result_o.sda_release = 1'b1; end
        ST_MACK_LOW:  begin
          result_o.scl_out     = 1'b0;
          result_o.sda_release = (left_d == 8'd0);
        end
        ST_MACK_HIGH: begin
          result_o.scl_out     = 1'b1;
          result_o.sda_release = (left_d == 8'd0);
        end
        ST_STOP_A:    begin result_o.scl_out = 1'b0; result_o.sda_release = 1'b0; end
        ST_STOP_B:    begin result_o.scl_out = 1'b1; result_o.sda_release = 1'b0; end
        default:      begin result_o.scl_out = 1'b1; result_o.sda_release = 1'b1; end
      endcase
    end
    result_o.busy_res     = (state_pre != ST_IDLE);
    result_o.data_request = (state_pre == ST_WAIT);

    // phase timer and end-of-phase transition
    phase_inc = phase_d + 8'd1;
    if (state_pre != ST_IDLE && state_pre != ST_WAIT) begin
      phase_d = phase_inc;
      if (phase_inc >= ticks) begin
        phase_d = 8'd0;
        if (state_pre[4] && !state_pre[3]) begin
          if (!state_pre[0]) begin
            state_d = state_pre + 5'd1;
          end else begin
            shift_d = {shift_d[6:0], 1'b0};
            bit_d   = bit_d + 4'd1;
            if (bit_d[3]) begin
              bit_d   = 4'd0;
              state_d = state_pre + 5'd7;   // into the matching ack phase
            end else begin
              state_d = state_pre - 5'd1;
            end
          end
        end else if (state_pre[4]) begin
          if (!state_pre[0]) begin
            state_d = state_pre + 5'd1;
          end else if (item_i.sda_in) begin
            case (kind)
              KIND_ADDR_W: status_d = STS_ADDR_NAK;
              KIND_ADDR_R: status_d = STS_ADDR_NAK;
              KIND_REG:    status_d = STS_REG_NAK;
              default:     status_d = STS_DATA_NAK;
            endcase
            state_d = ST_STOP_A;
          end else begin
            case (kind)
              KIND_ADDR_W: begin
                shift_d = regb_d;
                bit_d   = 4'd0;
                state_d = ST_TX_REG;
              end
              KIND_REG: begin
                if (is_read_d) state_d = ST_RS_A;
                else state_d = (left_d == 8'd0) ? ST_STOP_A : ST_WAIT;
              end
              KIND_ADDR_R: begin
                bit_d   = 4'd0;
                state_d = (left_d == 8'd0) ? ST_STOP_A : ST_RD_LOW;
              end
              default: begin
                left_d  = left_d - 8'd1;
                state_d = (left_d == 8'd0) ? ST_STOP_A : ST_WAIT;
              end
            endcase
          end
        end else begin
          case (state_pre)
            ST_START_A: state_d = ST_START_B;
            ST_START_B: begin
              shift_d = {device_address_i, 1'b0};
              bit_d   = 4'd0;
              state_d = ST_TX_ADDR_W;
            end
            ST_RS_A: state_d = ST_RS_B;
            ST_RS_B: state_d = ST_RS_C;
            ST_RS_C: begin
              shift_d = {device_address_i, 1'b1};
              bit_d   = 4'd0;
              state_d = ST_TX_ADDR_R;
            end
            ST_RD_LOW: state_d = ST_RD_HIGH;
            ST_RD_HIGH: begin
              shift_d = {shift_d[6:0], item_i.sda_in};
              bit_d   = bit_d + 4'd1;
              if (bit_d[3]) begin
                bit_d   = 4'd0;
                left_d  = left_d - 8'd1;
                result_o.read_valid    = 1'b1;
                result_o.read_byte_out = shift_d;
                state_d = ST_MACK_LOW;
              end else begin
                state_d = ST_RD_LOW;
              end
            end
            ST_MACK_LOW:  state_d = ST_MACK_HIGH;
            ST_MACK_HIGH: state_d = (left_d == 8'd0) ? ST_STOP_A : ST_RD_LOW;
            ST_STOP_A:    state_d = ST_STOP_B;
            ST_STOP_B:    state_d = ST_STOP_C;
            ST_STOP_C: begin
              state_d = ST_IDLE;
              result_o.done_res = 1'b1;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
    end
    result_o.status = status_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      phase_q   <= 8'd0;
      bit_q     <= 4'd0;
      shift_q   <= 8'd0;
      left_q    <= 8'd0;
      regb_q    <= 8'd0;
      is_read_q <= 1'b0;
      status_q  <= STS_OK;
    end else if (step_i) begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      bit_q     <= bit_d;
      shift_q   <= shift_d;
      left_q    <= left_d;
      regb_q    <= regb_d;
      is_read_q <= is_read_d;
      status_q  <= status_d;
    end
  end

endmodule

/* design/i2c_register_master_top.sv */
// top level: tick channel, configuration registers and result register
`timescale 1ns / 1ps

// Tick-driven I2C master for register writes and register reads.
// Each transfer on the in channel is one bus tick: an op (idle tick, begin
// write, begin read, supply write byte) together with the sampled SDA level.
// Each tick yields exactly one result on the out channel: SCL level, SDA
// release, a received byte with its valid flag, data request, busy, done
// and the status of the last transaction.
// The result of a tick sits in the output register the cycle after its
// transfer. Throughput is one tick per cycle while the receiver takes results;
// the sequencer state and the output register update on the same edge.
// When the receiver stalls, the pending result holds and in_ready_o drops
// until it is taken, so no tick is lost or repeated.
// The cfg channel is always ready: index 0 sets the 7-bit device address,
// index 1 the ticks per bus phase (0 acts as 1); other indexes are dropped.
// Reset returns the bus to idle (SCL and SDA released), clears status, sets
// device address 0 and 5 ticks per phase, and empties the output register.
module i2c_register_master_top import i2crm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_t        in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_t       out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  logic [6:0] dev_addr_q;
  logic [7:0] phase_ticks_q;
  logic       out_valid_q;
  out_t       out_data_q;
  out_t       result;
  logic       step;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign step        = in_valid_i && in_ready_o;

  i2crm_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (step),
    .item_i           (in_data_i),
    .device_address_i (dev_addr_q),
    .phase_ticks_i    (phase_ticks_q),
    .result_o         (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q    <= DEVICE_ADDRESS_RST;
      phase_ticks_q <= PHASE_TICKS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_DEVICE_ADDRESS: dev_addr_q    <= cfg_data_i[6:0];
        CFG_PHASE_TICKS:    phase_ticks_q <= cfg_data_i;
        default:            ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* tb/sv/i2c_register_master_top_tb.sv */
// testbench for the i2c register master: tick table, random bus traffic and a bus predictor
`timescale 1ns / 1ps

module i2c_register_master_top_tb import i2crm_pkg::*;;

  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_START_A   = 5'd1;
  localparam logic [4:0] S_START_B   = 5'd2;
  localparam logic [4:0] S_RS_A      = 5'd3;
  localparam logic [4:0] S_RS_B      = 5'd4;
  localparam logic [4:0] S_RS_C      = 5'd5;
  localparam logic [4:0] S_WAIT      = 5'd6;
  localparam logic [4:0] S_RD_LOW    = 5'd7;
  localparam logic [4:0] S_RD_HIGH   = 5'd8;
  localparam logic [4:0] S_MACK_LOW  = 5'd9;
  localparam logic [4:0] S_MACK_HIGH = 5'd10;
  localparam logic [4:0] S_STOP_A    = 5'd11;
  localparam logic [4:0] S_STOP_B    = 5'd12;
  localparam logic [4:0] S_STOP_C    = 5'd13;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_TICKS = 45;
  localparam int NUM_PHASES   = 6;

  typedef struct packed {
    logic       is_cfg;
    logic [1:0] cfg_idx;
    logic [7:0] cfg_val;
    in_t        tick;
    logic [7:0] reps;
    logic       typed;
    out_t       want;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_t        in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_t       out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  i2c_register_master_top uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // predicted bus master state
  logic [6:0] m_dev_addr = DEVICE_ADDRESS_RST;
  logic [7:0] m_phase_ticks = PHASE_TICKS_RST;
  logic [4:0] m_state = S_IDLE;
  logic [7:0] m_phase = '0;
  logic [3:0] m_bits = '0;
  logic [7:0] m_shift = '0;
  logic [7:0] m_left = '0;
  logic [7:0] m_reg = '0;
  logic       m_is_read = 1'b0;
  logic [1:0] m_status = STS_OK;

  out_t     bus_results_q[$];
  dir_row_t dir_rows[$];
  int       errors = 0;
  int       cycles = 0;
  int       stall = 0;
  bit       quiet = 1'b0;
  bit       doomed = 1'b0;

  task automatic load_byte(input logic [1:0] kind, input logic [7:0] value);
    m_shift = value;
    m_bits  = '0;
    m_state = {2'b10, kind, 1'b0};
  endtask

  // one bus tick: outputs come from the state after the op is taken,
  // status from the state after the phase ends
  task automatic advance_bus(input in_t it, output out_t r);
    logic [7:0] pt;
    logic [1:0] kind;
    logic       scl, rel, rvalid, done, busy, dreq;
    logic [7:0] rbyte;
    pt = (m_phase_ticks == 8'd0) ? 8'd1 : m_phase_ticks;
    rvalid = 1'b0;
    done = 1'b0;
    rbyte = '0;
    if (m_state == S_IDLE && (it.op == OP_WRITE || it.op == OP_READ)) begin
      m_reg = it.reg_addr;
      m_left = it.byte_count;
      m_is_read = (it.op == OP_READ);
      m_status = STS_OK;
      m_bits = '0;
      m_phase = '0;
      m_state = S_START_A;
    end else if (m_state == S_WAIT && it.op == OP_DATA) begin
      load_byte(KIND_DATA, it.write_data);
      m_phase = '0;
    end
    kind = m_state[2:1];
    if (m_state[4]) begin
      // shift phases drive the msb, ack phases release
      scl = m_state[0];
      rel = m_state[3] | m_shift[7];
    end else begin
      case (m_state)
        S_START_B, S_RS_C, S_STOP_B: begin
          scl = 1'b1;
          rel = 1'b0;
        end
        S_RS_A, S_WAIT, S_RD_LOW: begin
          scl = 1'b0;
          rel = 1'b1;
        end
        S_MACK_LOW: begin
          scl = 1'b0;
          rel = (m_left == 8'd0);
        end
        S_MACK_HIGH: begin
          scl = 1'b1;
          rel = (m_left == 8'd0);
        end
        S_STOP_A: begin
          scl = 1'b0;
          rel = 1'b0;
        end
        default: begin
          scl = 1'b1;
          rel = 1'b1;
        end
      endcase
    end
    busy = (m_state != S_IDLE);
    dreq = (m_state == S_WAIT);
    if (busy && !dreq) begin
      m_phase = m_phase + 8'd1;
      if (m_phase >= pt) begin
        m_phase = '0;
        if (m_state[4:3] == 2'b10) begin
          if (!m_state[0]) begin
            m_state = m_state + 5'd1;
          end else begin
            m_shift = {m_shift[6:0], 1'b0};
            m_bits = m_bits + 4'd1;
            if (m_bits >= 4'd8) begin
              m_bits = '0;
              m_state = {2'b11, kind, 1'b0};
            end else begin
              m_state = m_state - 5'd1;
            end
          end
        end else if (m_state[4:3] == 2'b11) begin
          if (!m_state[0]) begin
            m_state = m_state + 5'd1;
          end else if (it.sda_in) begin
            case (kind)
              KIND_REG:  m_status = STS_REG_NAK;
              KIND_DATA: m_status = STS_DATA_NAK;
              default:   m_status = STS_ADDR_NAK;
            endcase
            m_state = S_STOP_A;
          end else begin
            case (kind)
              KIND_ADDR_W: load_byte(KIND_REG, m_reg);
              KIND_REG: begin
                if (m_is_read) m_state = S_RS_A;
                else m_state = (m_left == 8'd0) ? S_STOP_A : S_WAIT;
              end
              KIND_ADDR_R: begin
                m_bits = '0;
                m_state = (m_left == 8'd0) ? S_STOP_A : S_RD_LOW;
              end
              default: begin
                m_left = m_left - 8'd1;
                m_state = (m_left == 8'd0) ? S_STOP_A : S_WAIT;
              end
            endcase
          end
        end else begin
          case (m_state)
            S_START_A:   m_state = S_START_B;
            S_START_B:   load_byte(KIND_ADDR_W, {m_dev_addr, 1'b0});
            S_RS_A:      m_state = S_RS_B;
            S_RS_B:      m_state = S_RS_C;
            S_RS_C:      load_byte(KIND_ADDR_R, {m_dev_addr, 1'b1});
            S_RD_LOW:    m_state = S_RD_HIGH;
            S_RD_HIGH: begin
              m_shift = {m_shift[6:0], it.sda_in};
              m_bits = m_bits + 4'd1;
              if (m_bits >= 4'd8) begin
                m_bits = '0;
                m_left = m_left - 8'd1;
                rvalid = 1'b1;
                rbyte = m_shift;
                m_state = S_MACK_LOW;
              end else begin
                m_state = S_RD_LOW;
              end
            end
            S_MACK_LOW:  m_state = S_MACK_HIGH;
            S_MACK_HIGH: m_state = (m_left == 8'd0) ? S_STOP_A : S_RD_LOW;
            S_STOP_A:    m_state = S_STOP_B;
            S_STOP_B:    m_state = S_STOP_C;
            S_STOP_C: begin
              m_state = S_IDLE;
              done = 1'b1;
            end
            default:     m_state = S_IDLE;
          endcase
        end
      end
    end
    r.scl_out       = scl;
    r.sda_release   = rel;
    r.read_byte_out = rbyte;
    r.read_valid    = rvalid;
    r.data_request  = dreq;
    r.busy_res      = busy;
    r.done_res      = done;
    r.status        = m_status;
  endtask

  function automatic in_t mk_in(input logic [1:0] op, input logic [7:0] ra,
                                input logic [7:0] cnt, input logic [7:0] wd,
                                input logic sda);
    in_t it;
    it.op = op;
    it.reg_addr = ra;
    it.byte_count = cnt;
    it.write_data = wd;
    it.sda_in = sda;
    return it;
  endfunction

  function automatic out_t mk_out(input logic scl, input logic rel, input logic [7:0] rb,
                                  input logic rv, input logic dreq, input logic busy,
                                  input logic done, input logic [1:0] st);
    out_t r;
    r.scl_out = scl;
    r.sda_release = rel;
    r.read_byte_out = rb;
    r.read_valid = rv;
    r.data_request = dreq;
    r.busy_res = busy;
    r.done_res = done;
    r.status = st;
    return r;
  endfunction

  function automatic void add_tick(input in_t it, input int reps, input bit typed,
                                   input out_t want);
    dir_row_t row;
    row = '0;
    row.tick = it;
    row.reps = 8'(reps);
    row.typed = typed;
    row.want = want;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_cfg(input logic [1:0] idx, input logic [7:0] val);
    dir_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.cfg_idx = idx;
    row.cfg_val = val;
    dir_rows.push_back(row);
  endfunction

  // random tick shaped by where the bus is; drain ends the transfer quickly
  function automatic in_t next_tick(input bit drain);
    in_t it;
    int  r;
    it.op = 2'($urandom_range(0, 3));
    it.reg_addr = 8'($urandom);
    it.byte_count = 8'($urandom);
    it.write_data = 8'($urandom);
    it.sda_in = 1'($urandom);
    r = $urandom_range(0, 99);
    if (m_state == S_IDLE) begin
      if (!drain && r < 60) begin
        it.op = (r < 30) ? OP_WRITE : OP_READ;
        // a long count only with an address nack so the bus gets back to idle
        doomed = ($urandom_range(0, 11) == 0);
        if (!doomed) it.byte_count = 8'($urandom_range(0, 3));
      end else begin
        it.op = (r % 2 == 0) ? OP_TICK : OP_DATA;
      end
    end else if (m_state == S_WAIT) begin
      if (drain || r < 60) it.op = OP_DATA;
    end else begin
      if (drain || r < 85) it.op = OP_TICK;
      if (m_state[4:3] == 2'b11 && m_state[0])
        it.sda_in = drain || doomed || ($urandom_range(0, 29) == 0);
    end
    return it;
  endfunction

  task automatic send_tick(input in_t it, input bit typed, input out_t want);
    out_t pred;
    int   gap;
    gap = quiet ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    advance_bus(it, pred);
    bus_results_q.push_back(typed ? want : pred);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    in_valid <= 1'b0;
    do @(posedge clk); while (bus_results_q.size() != 0);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_DEVICE_ADDRESS) m_dev_addr = val[6:0];
    else if (idx == CFG_PHASE_TICKS) m_phase_ticks = val;
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      if (errors < 50)
        $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // receiver: random stall per transfer, compare against the oldest prediction
  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (bus_results_q.size() == 0) begin
          $display("%0t unexpected transfer: expected none actual %0h", $time, out_data);
          errors++;
        end else begin
          want = bus_results_q.pop_front();
          check_field("scl_out", want.scl_out, out_data.scl_out);
          check_field("sda_release", want.sda_release, out_data.sda_release);
          check_field("read_byte_out", want.read_byte_out, out_data.read_byte_out);
          check_field("read_valid", want.read_valid, out_data.read_valid);
          check_field("data_request", want.data_request, out_data.data_request);
          check_field("busy_res", want.busy_res, out_data.busy_res);
          check_field("done_res", want.done_res, out_data.done_res);
          check_field("status", want.status, out_data.status);
        end
        stall = quiet ? 0 : $urandom_range(0, 16);
      end
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    dir_row_t   row;
    out_t       no_want;
    out_t       idle_out;
    logic [6:0] phase_addr [NUM_PHASES];
    logic [7:0] phase_pt [NUM_PHASES];
    int         p;
    int         n;
    no_want = '0;
    idle_out = mk_out(1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, STS_OK);

    // bus idle after reset, data op ignored when nothing waits
    add_tick(mk_in(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b1), 1, 1'b1, idle_out);
    add_tick(mk_in(OP_DATA, 8'hFF, 8'hFF, 8'hFF, 1'b0), 1, 1'b1, idle_out);
    add_cfg(CFG_DEVICE_ADDRESS, 8'h7F);
    add_cfg(CFG_PHASE_TICKS, 8'd1);
    // write refused at the address byte
    add_tick(mk_in(OP_WRITE, 8'h00, 8'h00, 8'h00, 1'b1), 1, 1'b0, no_want);
    add_tick(mk_in(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b1), 18, 1'b0, no_want);
    add_tick(mk_in(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b1), 1, 1'b1,
             mk_out(1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, STS_ADDR_NAK));
    add_tick(mk_in(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b1), 2, 1'b0, no_want);
    add_tick(mk_in(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b1), 1, 1'b1,
             mk_out(1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, STS_ADDR_NAK));
    // one byte write, extra data ops while shifting are ignored
    add_tick(mk_in(OP_WRITE, 8'hFF, 8'd1, 8'h00, 1'b0), 1, 1'b0, no_want);
    add_tick(mk_in(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0), 37, 1'b0, no_want);
    add_tick(mk_in(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0), 2, 1'b1,
             mk_out(1'b0, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, STS_OK));
    add_tick(mk_in(OP_DATA, 8'h00, 8'h00, 8'hA5, 1'b0), 1, 1'b0, no_want);
    add_tick(mk_in(OP_DATA, 8'h00, 8'h00, 8'h00, 1'b0), 17, 1'b0, no_want);
    add_tick(mk_in(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0), 3, 1'b0, no_want);
    // two byte read, begin while busy is ignored
    add_tick(mk_in(OP_READ, 8'h5A, 8'd2, 8'h00, 1'b0), 1, 1'b0, no_want);
    add_tick(mk_in(OP_WRITE, 8'h11, 8'd9, 8'h00, 1'b0), 1, 1'b0, no_want);
    add_tick(mk_in(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0), 57, 1'b0, no_want);
    add_tick(mk_in(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b1), 16, 1'b0, no_want);
    add_tick(mk_in(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0), 18, 1'b0, no_want);
    add_tick(mk_in(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b1), 5, 1'b0, no_want);
    // read of zero bytes stops after the read address
    add_tick(mk_in(OP_READ, 8'h00, 8'd0, 8'h00, 1'b0), 1, 1'b0, no_want);
    add_tick(mk_in(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0), 61, 1'b0, no_want);
    // zero phase ticks behave as one, zero byte write
    add_cfg(CFG_PHASE_TICKS, 8'd0);
    add_tick(mk_in(OP_WRITE, 8'h3C, 8'd0, 8'h00, 1'b0), 1, 1'b0, no_want);
    add_tick(mk_in(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0), 40, 1'b0, no_want);

    phase_addr[0] = 7'h00;
    phase_pt[0]   = 8'd0;
    phase_addr[1] = 7'h7F;
    phase_pt[1]   = 8'd1;
    phase_addr[2] = 7'($urandom_range(0, 127));
    phase_pt[2]   = 8'd2;
    phase_addr[3] = 7'h55;
    phase_pt[3]   = 8'd3;
    phase_addr[4] = 7'($urandom_range(0, 127));
    phase_pt[4]   = 8'd1;
    // slowest setting last so no drain is needed after it
    phase_addr[5] = 7'h2A;
    phase_pt[5]   = 8'd255;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (dir_rows.size() != 0) begin
      row = dir_rows.pop_front();
      if (row.is_cfg) begin
        write_reg(row.cfg_idx, row.cfg_val);
      end else begin
        repeat (row.reps) send_tick(row.tick, row.typed, row.want);
      end
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      write_reg(CFG_DEVICE_ADDRESS, {1'b0, phase_addr[p]});
      write_reg(CFG_PHASE_TICKS, phase_pt[p]);
      for (n = 0; n < RANDOM_TICKS; n++) begin
        if (n % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 199) == 0) begin
          in_valid <= 1'b0;
          do @(posedge clk); while (bus_results_q.size() != 0);
        end
        send_tick(next_tick(1'b0), 1'b0, no_want);
      end
      if (p < NUM_PHASES - 1) begin
        while (m_state != S_IDLE) send_tick(next_tick(1'b1), 1'b0, no_want);
      end
    end

    in_valid <= 1'b0;
    while (bus_results_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0 && bus_results_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
